[design/vector_to_heading_and_magnitude_assert.svh]
// Assertion macros for the vector-to-heading block and its checker.
// Depends on nothing; included by the checker file.
`ifndef VECTOR_TO_HEADING_AND_MAGNITUDE_ASSERT_SVH
`define VECTOR_TO_HEADING_AND_MAGNITUDE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define V2HM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define V2HM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/v2hm_pkg.sv]
// Types and constants for the vector-to-heading block.
// Depends on nothing; used by the top level and its checker.
package v2hm_pkg;

  localparam int unsigned COMP_WIDTH = 16;
  localparam int unsigned GUARD_BITS = 16;
  // CORDIC x/y width: scaled input plus room for gain and sign.
  localparam int unsigned XW         = COMP_WIDTH + GUARD_BITS + 3;
  localparam int unsigned ZW         = 24;   // signed angle, 1/16384 degree
  localparam int unsigned HW         = 23;   // unsigned heading, 1/16384 degree
  localparam int unsigned HEAD_W     = 15;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned XS_W       = XW - 1;
  localparam int unsigned LO_W       = XS_W / 2;
  localparam int unsigned HI_W       = XS_W - LO_W;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned PROD_W     = LO_W + GAIN_W;
  localparam int unsigned SUM_W      = XS_W + GAIN_W + 1;
  localparam int unsigned MAG_SHIFT  = GUARD_BITS + 24;

  localparam logic [GAIN_W-1:0] GAIN_INV = 24'd10188014;
  localparam logic [HW-1:0]     DEG_90   = 23'd1474560;
  localparam logic [HW-1:0]     DEG_180  = 23'd2949120;
  localparam logic [HW-1:0]     DEG_360  = 23'd5898240;
  localparam logic [HW-1:0]     HEAD_RND = 23'd128;
  localparam logic [HEAD_W-1:0] FULL_TURN = 15'd23040;
  localparam logic [HEAD_W-1:0] HEAD_N    = 15'd0;
  localparam logic [HEAD_W-1:0] HEAD_E    = 15'd5760;
  localparam logic [HEAD_W-1:0] HEAD_S    = 15'd11520;
  localparam logic [HEAD_W-1:0] HEAD_W_   = 15'd17280;
  localparam logic [MAG_W-1:0]  MAG_MAX   = 16'hFFFF;
  localparam logic [XS_W-1:0]   XS_SAT    = XS_W'(64'd131070 << GUARD_BITS);

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] x_comp;
    logic signed [COMP_WIDTH-1:0] y_comp;
  } v2hm_in_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic [MAG_W-1:0]  magnitude;
  } v2hm_res_t;

  // Side information that rides alongside the CORDIC data.
  typedef struct packed {
    logic              axis;
    logic              x_pos;
    logic              y_pos;
    logic [HEAD_W-1:0] axis_head;
    logic [MAG_W-1:0]  axis_mag;
  } v2hm_side_t;

  // atan(2^-i) in 1/16384 degree, rounded to nearest.
  function automatic logic [19:0] atan_fine(input int unsigned idx);
    logic [19:0] r;
    case (idx)
      0:  r = 20'd737280;
      1:  r = 20'd435242;
      2:  r = 20'd229970;
      3:  r = 20'd116736;
      4:  r = 20'd58595;
      5:  r = 20'd29326;
      6:  r = 20'd14667;
      7:  r = 20'd7334;
      8:  r = 20'd3667;
      9:  r = 20'd1833;
      10: r = 20'd917;
      11: r = 20'd458;
      12: r = 20'd229;
      13: r = 20'd115;
      14: r = 20'd57;
      15: r = 20'd29;
      16: r = 20'd14;
      17: r = 20'd7;
      18: r = 20'd4;
      19: r = 20'd2;
      20: r = 20'd1;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

[design/vector_to_heading_and_magnitude.sv]
// Heading and length of an (x, y) word by a pipelined CORDIC; uses v2hm_pkg.
// A word accepted while start_i is high is registered in stage 0, passes the CORDIC
//   iteration stages and post stages 1 and 2, and is then shown on res_o with valid_o high.
// Throughput: one word per cycle; busy_o is always low and the receiver cannot stall.
// The rate is set by the unrolled CORDIC: one iteration per pipeline stage.
// Reset (rst_ni low, asynchronous) clears every valid bit; data registers keep junk.
module vector_to_heading_and_magnitude #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  v2hm_pkg::v2hm_in_t   in_i,
  output logic                 valid_o,
  output v2hm_pkg::v2hm_res_t  res_o
);

  localparam int unsigned XW     = v2hm_pkg::XW;
  localparam int unsigned ZW     = v2hm_pkg::ZW;
  localparam int unsigned HW     = v2hm_pkg::HW;
  localparam int unsigned CW     = v2hm_pkg::COMP_WIDTH;
  localparam int unsigned XS_W   = v2hm_pkg::XS_W;
  localparam int unsigned LO_W   = v2hm_pkg::LO_W;
  localparam int unsigned HI_W   = v2hm_pkg::HI_W;
  localparam int unsigned PROD_W = v2hm_pkg::PROD_W;
  localparam int unsigned SUM_W  = v2hm_pkg::SUM_W;

  // The pipeline never pushes back.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 0: fold into the first quadrant, flag the axis cases.
  // ---------------------------------------------------------------------------
  logic               accept;
  logic [CW:0]        ax, ay;
  logic [CW:0]        axis_sum;
  v2hm_pkg::v2hm_side_t side0_d;
  logic signed [XW-1:0] cx0_d, cy0_d;

  assign accept = start_i && !busy_o;

  always_comb begin
    ax = in_i.x_comp[CW-1] ? ((CW+1)'(0) - {in_i.x_comp[CW-1], in_i.x_comp})
                           : {1'b0, in_i.x_comp};
    ay = in_i.y_comp[CW-1] ? ((CW+1)'(0) - {in_i.y_comp[CW-1], in_i.y_comp})
                           : {1'b0, in_i.y_comp};
    axis_sum = ax + ay;

    side0_d.axis  = (in_i.x_comp == '0) || (in_i.y_comp == '0);
    side0_d.x_pos = !in_i.x_comp[CW-1];
    side0_d.y_pos = !in_i.y_comp[CW-1];
    // Exact headings on the axes; the origin reads as north.
    if (!in_i.x_comp[CW-1] && in_i.x_comp != '0) begin
      side0_d.axis_head = v2hm_pkg::HEAD_E;
    end else if (in_i.x_comp[CW-1]) begin
      side0_d.axis_head = v2hm_pkg::HEAD_W_;
    end else if (in_i.y_comp[CW-1]) begin
      side0_d.axis_head = v2hm_pkg::HEAD_S;
    end else begin
      side0_d.axis_head = v2hm_pkg::HEAD_N;
    end
    side0_d.axis_mag = axis_sum[v2hm_pkg::MAG_W-1:0];

    // CORDIC works on (|y|, |x|) with guard bits below.
    cx0_d = XW'({ay, {v2hm_pkg::GUARD_BITS{1'b0}}});
    cy0_d = XW'({ax, {v2hm_pkg::GUARD_BITS{1'b0}}});
  end

  // Stage arrays: index 0 is the input stage, index i+1 holds iteration i.
  logic                 vld_q  [CORDIC_STEPS+1];
  v2hm_pkg::v2hm_side_t side_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] cx_q   [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy_q   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q    [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side0_d;
    cx_q[0]   <= cx0_d;
    cy_q[0]   <= cy0_d;
    z_q[0]    <= '0;
  end

  // ---------------------------------------------------------------------------
  // CORDIC vectoring: one iteration per stage, drive y toward zero.
  // Arithmetic right shift gives floor rounding of the shifted terms.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN = ZW'(v2hm_pkg::atan_fine(i));
    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] cx_d, cy_d;
    logic signed [ZW-1:0] z_d;

    always_comb begin
      dx = cy_q[i] >>> i;
      dy = cx_q[i] >>> i;
      if (!cy_q[i][XW-1]) begin
        cx_d = cx_q[i] + dx;
        cy_d = cy_q[i] - dy;
        z_d  = z_q[i] + ATAN;
      end else begin
        cx_d = cx_q[i] - dx;
        cy_d = cy_q[i] + dy;
        z_d  = z_q[i] - ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i+1] <= side_q[i];
      cx_q[i+1]   <= cx_d;
      cy_q[i+1]   <= cy_d;
      z_q[i+1]    <= z_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Post stage 1: clamp the angle and place it in its quadrant; split the
  // gain correction into two narrow partial products.
  // ---------------------------------------------------------------------------
  localparam int unsigned L = CORDIC_STEPS;

  logic [HW-1:0]    zc, h_d;
  logic [XS_W-1:0]  xs;
  logic             sat_d;
  logic [PROD_W-1:0] pl_d;
  logic [HI_W+v2hm_pkg::GAIN_W-1:0] ph_d;

  always_comb begin
    if (z_q[L][ZW-1]) begin
      zc = '0;
    end else if (z_q[L] > $signed({1'b0, v2hm_pkg::DEG_90})) begin
      zc = v2hm_pkg::DEG_90;
    end else begin
      zc = z_q[L][HW-1:0];
    end

    if (side_q[L].x_pos && side_q[L].y_pos) begin
      h_d = zc;
    end else if (side_q[L].x_pos) begin
      h_d = v2hm_pkg::DEG_180 - zc;
    end else if (!side_q[L].y_pos) begin
      h_d = v2hm_pkg::DEG_180 + zc;
    end else begin
      h_d = v2hm_pkg::DEG_360 - zc;
    end

    xs    = cx_q[L][XW-1] ? '0 : cx_q[L][XS_W-1:0];
    sat_d = xs > v2hm_pkg::XS_SAT;
    pl_d  = PROD_W'(xs[LO_W-1:0]) * PROD_W'(v2hm_pkg::GAIN_INV);
    ph_d  = (HI_W+v2hm_pkg::GAIN_W)'(xs[XS_W-1:LO_W])
          * (HI_W+v2hm_pkg::GAIN_W)'(v2hm_pkg::GAIN_INV);
  end

  logic                 p1_vld_q;
  v2hm_pkg::v2hm_side_t p1_side_q;
  logic [HW-1:0]        p1_h_q;
  logic                 p1_sat_q;
  logic [PROD_W-1:0]    p1_pl_q;
  logic [HI_W+v2hm_pkg::GAIN_W-1:0] p1_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= vld_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    p1_side_q <= side_q[L];
    p1_h_q    <= h_d;
    p1_sat_q  <= sat_d;
    p1_pl_q   <= pl_d;
    p1_ph_q   <= ph_d;
  end

  // ---------------------------------------------------------------------------
  // Post stage 2: round the heading to 1/64 degree and wrap a full turn;
  // join the partial products, round and saturate the length.
  // ---------------------------------------------------------------------------
  logic [HW-1:0]     h_rnd;
  logic [v2hm_pkg::HEAD_W-1:0] head;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-v2hm_pkg::MAG_SHIFT-1:0] m;
  v2hm_pkg::v2hm_res_t res_d;

  always_comb begin
    h_rnd = p1_h_q + v2hm_pkg::HEAD_RND;
    head  = h_rnd[HW-1:8];
    if (head >= v2hm_pkg::FULL_TURN) begin
      head = head - v2hm_pkg::FULL_TURN;
    end

    sum = (SUM_W'(p1_ph_q) << LO_W) + SUM_W'(p1_pl_q)
        + (SUM_W'(1) << (v2hm_pkg::MAG_SHIFT - 1));
    m   = sum[SUM_W-1:v2hm_pkg::MAG_SHIFT];

    if (p1_side_q.axis) begin
      res_d.heading   = p1_side_q.axis_head;
      res_d.magnitude = p1_side_q.axis_mag;
    end else begin
      res_d.heading = head;
      if (p1_sat_q || m > (SUM_W-v2hm_pkg::MAG_SHIFT)'(v2hm_pkg::MAG_MAX)) begin
        res_d.magnitude = v2hm_pkg::MAG_MAX;
      end else begin
        res_d.magnitude = m[v2hm_pkg::MAG_W-1:0];
      end
    end
  end

  logic                valid_q;
  v2hm_pkg::v2hm_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[design/v2hm_checker.sv]
// Port-level checker for the vector-to-heading block, bound to its top level.
// Depends on v2hm_pkg and vector_to_heading_and_magnitude_assert.svh.
`include "vector_to_heading_and_magnitude_assert.svh"

module v2hm_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input v2hm_pkg::v2hm_in_t  in_i,
  input logic                valid_o,
  input v2hm_pkg::v2hm_res_t res_o
);

  localparam int unsigned LAT = CORDIC_STEPS + 3;

  `V2HM_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o, "busy raised")
  `V2HM_ASSERT_IMPLY(a_heading_range, clk_i, rst_ni, valid_o, res_o.heading < v2hm_pkg::FULL_TURN, "heading out of range")
  `V2HM_ASSERT_IMPLY(a_fixed_latency, clk_i, rst_ni, valid_o, $past(start_i && !busy_o, LAT), "result without word")
  `V2HM_ASSERT_IMPLY(a_origin, clk_i, rst_ni, valid_o && $past(in_i.x_comp == '0 && in_i.y_comp == '0, LAT), res_o.heading == '0 && res_o.magnitude == '0, "origin not zero")
  `V2HM_ASSERT_IMPLY(a_east_axis, clk_i, rst_ni, valid_o && $past(in_i.y_comp == '0 && in_i.x_comp > 0, LAT), res_o.heading == v2hm_pkg::HEAD_E, "east axis wrong")

endmodule

bind vector_to_heading_and_magnitude v2hm_checker #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_v2hm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .in_i   (in_i),
  .valid_o(valid_o),
  .res_o  (res_o)
);
